// ===== hdl/eur_pkg.sv =====
// Shared constants and types for the encoder unwrap and rate averager.
package eur_pkg;

    localparam int AVERAGE_DEPTH   = 8;
    localparam int SLOT_W          = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;

    localparam int READ_W          = 13;
    localparam int RATE_W          = 14;
    localparam int COUNT_W         = 14;
    localparam int ANGLE_W         = 20;

    localparam int COUNTS_PER_TURN = 8192;
    localparam int HALF_TURN       = 4096;
    localparam int ANGLE_PER_COUNT = 45;
    localparam int ANGLE_PER_TURN  = 368640;
    localparam int THRESHOLD_RESET = 7500;

    // running sum and its magnitude
    localparam int SUM_W           = RATE_W + SLOT_W;
    localparam int MAG_W           = SUM_W - 1;

    // reciprocal for exact floor(mag / AVERAGE_DEPTH)
    localparam int DIV_SHIFT       = MAG_W + SLOT_W;
    localparam int RCP_W           = DIV_SHIFT - SLOT_W + 2;
    localparam int RECIP           = ((1 << DIV_SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
    localparam int PROD_W          = MAG_W + RCP_W;

    typedef struct packed {
        logic              vld;
        logic [SLOT_W-1:0] slot;
        logic [RATE_W-1:0] rate;
    } t_avg_in;

endpackage

// ===== hdl/eur_avg.sv =====
// Ring memory of step rates, running sum and average by constant reciprocal.
module eur_avg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  eur_pkg::t_avg_in               i_req,
    output logic signed [eur_pkg::RATE_W-1:0] o_average
);

    logic [eur_pkg::RATE_W-1:0] mem [eur_pkg::AVERAGE_DEPTH];
    logic [eur_pkg::RATE_W-1:0] r_q;
    logic                       r_written [eur_pkg::AVERAGE_DEPTH];

    logic                        r_b_vld;
    logic [eur_pkg::SLOT_W-1:0]  r_b_slot;
    logic [eur_pkg::RATE_W-1:0]  r_b_rate;
    logic                        r_b_fwd;
    logic [eur_pkg::RATE_W-1:0]  r_b_fwd_data;
    logic                        r_b_hit;

    logic signed [eur_pkg::SUM_W-1:0] r_sum;
    logic signed [eur_pkg::SUM_W-1:0] n_sum;
    logic [eur_pkg::SUM_W-1:0]        n_abs;
    logic [eur_pkg::MAG_W-1:0]        r_c_mag;
    logic                             r_c_neg;

    logic                          rd_en;
    logic                          wr_en;
    logic [eur_pkg::RATE_W-1:0]    old_rate;
    logic [eur_pkg::RCP_W-1:0]     recip;
    logic [eur_pkg::PROD_W-1:0]    prod;
    logic [eur_pkg::READ_W-1:0]    quot;

    assign rd_en = i_adv && i_req.vld;
    assign wr_en = i_adv && r_b_vld;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_b_slot] <= r_b_rate;
        end
        if (rd_en) begin
            r_q <= mem[i_req.slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < eur_pkg::AVERAGE_DEPTH; i++) begin
                r_written[i] <= 1'b0;
            end
            r_b_vld <= 1'b0;
            r_sum   <= '0;
        end else begin
            if (wr_en) begin
                r_written[r_b_slot] <= 1'b1;
                r_sum               <= n_sum;
            end
            if (i_adv) begin
                r_b_vld <= i_req.vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_b_slot     <= i_req.slot;
            r_b_rate     <= i_req.rate;
            r_b_fwd      <= wr_en && (r_b_slot == i_req.slot);
            r_b_fwd_data <= r_b_rate;
            r_b_hit      <= r_written[i_req.slot];
        end
        if (wr_en) begin
            r_c_mag <= n_abs[eur_pkg::MAG_W-1:0];
            r_c_neg <= n_sum[eur_pkg::SUM_W-1];
        end
    end

    always_comb begin
        if (r_b_fwd) begin
            old_rate = r_b_fwd_data;
        end else if (r_b_hit) begin
            old_rate = r_q;
        end else begin
            old_rate = '0;
        end
        n_sum = r_sum
              - eur_pkg::SUM_W'($signed(old_rate))
              + eur_pkg::SUM_W'($signed(r_b_rate));
        n_abs = n_sum[eur_pkg::SUM_W-1] ? eur_pkg::SUM_W'(-n_sum) : eur_pkg::SUM_W'(n_sum);
    end

    assign recip = eur_pkg::RCP_W'(eur_pkg::RECIP);
    assign prod  = eur_pkg::PROD_W'(r_c_mag) * eur_pkg::PROD_W'(recip);
    assign quot  = prod[eur_pkg::DIV_SHIFT +: eur_pkg::READ_W];

    assign o_average = r_c_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

endmodule

// ===== hdl/encoder_unwrap_rate_averager.sv =====
// Top level: encoder wrap correction, continuous count, angle and averaged rate.
//
//  channel   direction  handshake                 payload
//  cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_data (wrap threshold)
//  in        in         i_in_valid/o_in_ready     i_raw_angle
//  out       out        o_out_valid/i_out_ready   rate, count, angle, average, turn
//
// One reading per cycle while no result is held; results pass stages b, c and out.
// The ring memory is read in the accept cycle and written as the reading leaves
// stage b, with forwarding when both touch the same slot.
// Reset clears the per-slot written bits at once; no clearing pass is needed.
// A held result freezes the whole pipe; cfg is always ready.
module encoder_unwrap_rate_averager (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [eur_pkg::READ_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [eur_pkg::READ_W-1:0]         i_raw_angle,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [eur_pkg::RATE_W-1:0]  o_step_rate,
    output logic [eur_pkg::COUNT_W-1:0]        o_continuous_count,
    output logic [eur_pkg::ANGLE_W-1:0]        o_angle_fixed,
    output logic signed [eur_pkg::RATE_W-1:0]  o_average_rate,
    output logic                               o_turn_flag
);

    logic [eur_pkg::READ_W-1:0] r_thr;
    logic [eur_pkg::READ_W-1:0] r_prev;
    logic                       r_turn;
    logic                       r_started;
    logic [eur_pkg::SLOT_W-1:0] r_pos;

    logic                       r_b_vld;
    logic [eur_pkg::RATE_W-1:0] r_b_rate;
    logic [eur_pkg::READ_W-1:0] r_b_reading;
    logic                       r_b_turn;

    logic                        r_c_vld;
    logic [eur_pkg::RATE_W-1:0]  r_c_rate;
    logic [eur_pkg::COUNT_W-1:0] r_c_count;
    logic [eur_pkg::ANGLE_W-1:0] r_c_angle;
    logic                        r_c_turn;

    logic                        r_out_vld;
    logic [eur_pkg::RATE_W-1:0]  r_out_rate;
    logic [eur_pkg::COUNT_W-1:0] r_out_count;
    logic [eur_pkg::ANGLE_W-1:0] r_out_angle;
    logic [eur_pkg::RATE_W-1:0]  r_out_avg;
    logic                        r_out_turn;

    logic                        adv;
    logic                        accept;
    logic [eur_pkg::RATE_W-1:0]  diff;
    logic signed [eur_pkg::RATE_W:0] diff_s;
    logic signed [eur_pkg::RATE_W:0] thr_s;
    logic                        wrap_dn;
    logic                        wrap_up;
    logic                        first_turn;
    logic                        a_turn;
    logic [eur_pkg::RATE_W-1:0]  a_rate;
    logic [eur_pkg::SLOT_W-1:0]  n_pos;
    logic [eur_pkg::ANGLE_W-1:0] b_angle;
    eur_pkg::t_avg_in            avg_req;
    logic signed [eur_pkg::RATE_W-1:0] c_avg;

    assign adv         = !r_out_vld || i_out_ready;
    assign accept      = i_in_valid && adv;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        diff    = {1'b0, i_raw_angle} - {1'b0, r_prev};
        diff_s  = $signed({diff[eur_pkg::RATE_W-1], diff});
        thr_s   = $signed({2'b00, r_thr});
        wrap_dn = diff_s < -thr_s;
        wrap_up = diff_s > thr_s;

        if (i_raw_angle > eur_pkg::READ_W'(eur_pkg::HALF_TURN)) begin
            first_turn = 1'b0;
        end else if (i_raw_angle < eur_pkg::READ_W'(eur_pkg::HALF_TURN)) begin
            first_turn = 1'b1;
        end else begin
            first_turn = r_turn;
        end

        if (wrap_dn) begin
            a_turn = 1'b1;
            a_rate = diff + eur_pkg::RATE_W'(eur_pkg::COUNTS_PER_TURN);
        end else if (wrap_up) begin
            a_turn = 1'b0;
            a_rate = diff - eur_pkg::RATE_W'(eur_pkg::COUNTS_PER_TURN);
        end else begin
            a_turn = r_started ? r_turn : first_turn;
            a_rate = diff;
        end

        if (r_pos == eur_pkg::SLOT_W'(eur_pkg::AVERAGE_DEPTH - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 1'b1;
        end

        avg_req.vld  = accept;
        avg_req.slot = r_pos;
        avg_req.rate = a_rate;

        b_angle = eur_pkg::ANGLE_W'(r_b_reading) * eur_pkg::ANGLE_W'(eur_pkg::ANGLE_PER_COUNT)
                + (r_b_turn ? eur_pkg::ANGLE_W'(eur_pkg::ANGLE_PER_TURN) : '0);
    end

    eur_avg u_avg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_req     (avg_req),
        .o_average (c_avg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= eur_pkg::READ_W'(eur_pkg::THRESHOLD_RESET);
            r_prev    <= '0;
            r_turn    <= 1'b0;
            r_started <= 1'b0;
            r_pos     <= '0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (accept) begin
                r_prev    <= i_raw_angle;
                r_turn    <= a_turn;
                r_started <= 1'b1;
                r_pos     <= n_pos;
            end
            if (adv) begin
                r_b_vld   <= accept;
                r_c_vld   <= r_b_vld;
                r_out_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_rate    <= a_rate;
            r_b_reading <= i_raw_angle;
            r_b_turn    <= a_turn;
        end
        if (adv && r_b_vld) begin
            r_c_rate  <= r_b_rate;
            r_c_count <= {r_b_turn, r_b_reading};
            r_c_angle <= b_angle;
            r_c_turn  <= r_b_turn;
        end
        if (adv && r_c_vld) begin
            r_out_rate  <= r_c_rate;
            r_out_count <= r_c_count;
            r_out_angle <= r_c_angle;
            r_out_avg   <= c_avg;
            r_out_turn  <= r_c_turn;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_step_rate        = $signed(r_out_rate);
    assign o_continuous_count = r_out_count;
    assign o_angle_fixed      = r_out_angle;
    assign o_average_rate     = $signed(r_out_avg);
    assign o_turn_flag        = r_out_turn;

endmodule

// ===== hdl/eur_checker.sv =====
// Port-level checks for the encoder unwrap and rate averager, with bind.
module eur_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [eur_pkg::RATE_W-1:0]  o_step_rate,
    input  logic [eur_pkg::COUNT_W-1:0]        o_continuous_count,
    input  logic [eur_pkg::ANGLE_W-1:0]        o_angle_fixed,
    input  logic signed [eur_pkg::RATE_W-1:0]  o_average_rate,
    input  logic                               o_turn_flag
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_step_rate)
            && $stable(o_average_rate) && $stable(o_angle_fixed))
        else $error("stalled result changed");

    a_count_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_continuous_count[13] == o_turn_flag)
        else $error("count turn bit mismatches turn flag");

    a_angle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_angle_fixed == 20'(o_continuous_count[12:0]) * 20'd45
            + (o_turn_flag ? 20'd368640 : 20'd0))
        else $error("angle inconsistent with count");

endmodule

bind encoder_unwrap_rate_averager eur_checker u_eur_checker (.*);

// ===== tb/encoder_unwrap_rate_averager_tb.sv =====
// Self-checking testbench for the encoder unwrap and rate averager, with a scoreboard class.
module encoder_unwrap_rate_averager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 4;
    localparam int RESET_TICKS = 12;
    localparam int IDLE_PCT    = 32;
    localparam int LONG_HOLD   = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_TICKS  = 8;
    localparam int READ_MAX    = (1 << eur_pkg::READ_W) - 1;

    typedef struct {
        logic signed [eur_pkg::RATE_W-1:0] step_rate;
        logic [eur_pkg::COUNT_W-1:0]       count;
        logic [eur_pkg::ANGLE_W-1:0]       angle;
        logic signed [eur_pkg::RATE_W-1:0] avg_rate;
        logic                              turn;
    } t_readout;

    class unwrap_checker;
        int                         threshold;
        logic [eur_pkg::READ_W-1:0] last_reading;
        logic                       turn;
        bit                         started;
        int                         ring_rates[eur_pkg::AVERAGE_DEPTH];
        int                         ring_slot;
        int                         rate_sum;
        int                         failures;
        t_readout                   pending_readouts[$];

        function new();
            threshold    = eur_pkg::THRESHOLD_RESET;
            last_reading = '0;
            turn         = 1'b0;
            started      = 1'b0;
            ring_slot    = 0;
            rate_sum     = 0;
            failures     = 0;
            foreach (ring_rates[i]) ring_rates[i] = 0;
        endfunction

        function void set_threshold(logic [eur_pkg::READ_W-1:0] value);
            threshold = int'(value);
        endfunction

        function void predict_reading(logic [eur_pkg::READ_W-1:0] reading);
            t_readout r;
            int       diff;
            int       rate;
            int       count;
            int       angle;
            int       avg;
            if (!started) begin
                if (reading > eur_pkg::HALF_TURN)
                    turn = 1'b0;
                else if (reading < eur_pkg::HALF_TURN)
                    turn = 1'b1;
                started = 1'b1;
            end
            diff = int'(reading) - int'(last_reading);
            last_reading = reading;
            if (diff < -threshold) begin
                turn = 1'b1;
                rate = diff + eur_pkg::COUNTS_PER_TURN;
            end else if (diff > threshold) begin
                turn = 1'b0;
                rate = diff - eur_pkg::COUNTS_PER_TURN;
            end else begin
                rate = diff;
            end
            rate_sum = rate_sum - ring_rates[ring_slot] + rate;
            ring_rates[ring_slot] = rate;
            ring_slot = (ring_slot + 1) % eur_pkg::AVERAGE_DEPTH;
            avg   = rate_sum / eur_pkg::AVERAGE_DEPTH;
            count = int'(reading) + (turn ? eur_pkg::COUNTS_PER_TURN : 0);
            angle = int'(reading) * eur_pkg::ANGLE_PER_COUNT
                  + (turn ? eur_pkg::ANGLE_PER_TURN : 0);
            r.step_rate = rate[eur_pkg::RATE_W-1:0];
            r.count     = count[eur_pkg::COUNT_W-1:0];
            r.angle     = angle[eur_pkg::ANGLE_W-1:0];
            r.avg_rate  = avg[eur_pkg::RATE_W-1:0];
            r.turn      = turn;
            pending_readouts.push_back(r);
        endfunction

        function void mismatch(string field, int want, int got);
            failures++;
            $error("%s: expected %0d, actual %0d", field, want, got);
        endfunction

        function void check_readout(logic signed [eur_pkg::RATE_W-1:0] step_rate,
                                    logic [eur_pkg::COUNT_W-1:0] count,
                                    logic [eur_pkg::ANGLE_W-1:0] angle,
                                    logic signed [eur_pkg::RATE_W-1:0] avg_rate,
                                    logic turn_flag);
            t_readout want;
            if (pending_readouts.size() == 0) begin
                failures++;
                $error("result transaction with no reading outstanding");
                return;
            end
            want = pending_readouts.pop_front();
            if (step_rate !== want.step_rate)
                mismatch("step_rate", int'(want.step_rate), int'(step_rate));
            if (count !== want.count)
                mismatch("continuous_count", int'(want.count), int'(count));
            if (angle !== want.angle)
                mismatch("angle_fixed", int'(want.angle), int'(angle));
            if (avg_rate !== want.avg_rate)
                mismatch("average_rate", int'(want.avg_rate), int'(avg_rate));
            if (turn_flag !== want.turn)
                mismatch("turn_flag", int'(want.turn), int'(turn_flag));
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [eur_pkg::READ_W-1:0]        i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [eur_pkg::READ_W-1:0]        i_raw_angle;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic signed [eur_pkg::RATE_W-1:0] o_step_rate;
    logic [eur_pkg::COUNT_W-1:0]       o_continuous_count;
    logic [eur_pkg::ANGLE_W-1:0]       o_angle_fixed;
    logic signed [eur_pkg::RATE_W-1:0] o_average_rate;
    logic                              o_turn_flag;

    unwrap_checker sb;
    int            idle_pct;
    bit            hold_pending;
    int            stall_cycles;
    int            walk_pos;
    int            walk_speed;

    encoder_unwrap_rate_averager uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_raw_angle        (i_raw_angle),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_step_rate        (o_step_rate),
        .o_continuous_count (o_continuous_count),
        .o_angle_fixed      (o_angle_fixed),
        .o_average_rate     (o_average_rate),
        .o_turn_flag        (o_turn_flag)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // transaction monitor: results are checked before the same-edge reading is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_readout(o_step_rate, o_continuous_count, o_angle_fixed,
                                 o_average_rate, o_turn_flag);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_threshold(i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.predict_reading(i_raw_angle);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready  = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end
            i_out_ready = ($urandom_range(0, 99) >= idle_pct);
            @(negedge i_clk);
        end
    end

    task automatic send_reading(input logic [eur_pkg::READ_W-1:0] reading);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_raw_angle = reading;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_in_valid = 1'b0;
        while (sb.pending_readouts.size() != 0) @(posedge i_clk);
        repeat (TAIL_TICKS) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [eur_pkg::READ_W-1:0] value);
        wait_for_drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // mostly a rotating shaft with varying speed, the rest arbitrary jumps
    task automatic run_motion(input int n);
        int                         k;
        logic [eur_pkg::READ_W-1:0] reading;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                if ($urandom_range(0, 3) == 0)
                    walk_speed = int'($urandom_range(0, 8000)) - 4000;
                else
                    walk_speed = int'($urandom_range(0, 600)) - 300;
            end
            if ($urandom_range(0, 99) < 78) begin
                walk_pos = (walk_pos + walk_speed) & READ_MAX;
                reading  = walk_pos[eur_pkg::READ_W-1:0];
            end else begin
                case ($urandom_range(0, 3))
                    0:       reading = '0;
                    1:       reading = eur_pkg::READ_W'(READ_MAX);
                    default: reading = eur_pkg::READ_W'($urandom_range(0, READ_MAX));
                endcase
            end
            send_reading(reading);
        end
    endtask

    initial begin
        logic [eur_pkg::READ_W-1:0] first_reading;
        sb           = new();
        idle_pct     = IDLE_PCT;
        hold_pending = 1'b0;
        walk_pos     = 0;
        walk_speed   = 37;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_raw_angle  = '0;
        i_out_ready  = 1'b0;
        repeat (RESET_TICKS) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // first reading: exactly half a turn, below it or above it
        case ($urandom_range(0, 2))
            0:       first_reading = eur_pkg::READ_W'(eur_pkg::HALF_TURN);
            1:       first_reading = eur_pkg::READ_W'($urandom_range(0,
                                                      eur_pkg::HALF_TURN - 1));
            default: first_reading = eur_pkg::READ_W'($urandom_range(
                                                      eur_pkg::HALF_TURN + 1, READ_MAX));
        endcase
        send_reading(first_reading);
        // wrap both ways, threshold edges, zero step
        send_reading('0);
        send_reading(eur_pkg::READ_W'(READ_MAX));
        send_reading('0);
        send_reading(eur_pkg::READ_W'(eur_pkg::THRESHOLD_RESET));
        send_reading('0);
        send_reading(eur_pkg::READ_W'(eur_pkg::THRESHOLD_RESET + 1));
        send_reading('0);
        send_reading(eur_pkg::READ_W'(eur_pkg::HALF_TURN));
        send_reading(eur_pkg::READ_W'(eur_pkg::HALF_TURN - 1));
        send_reading(eur_pkg::READ_W'(eur_pkg::HALF_TURN + 1));
        send_reading(eur_pkg::READ_W'(READ_MAX));
        send_reading(eur_pkg::READ_W'(READ_MAX));
        send_reading(eur_pkg::READ_W'(1));
        send_reading(eur_pkg::READ_W'(READ_MAX - 1));
        run_motion(80);

        // zero threshold: every rise wraps
        write_threshold('0);
        send_reading(eur_pkg::READ_W'(100));
        send_reading(eur_pkg::READ_W'(100));
        send_reading(eur_pkg::READ_W'(99));
        send_reading(eur_pkg::READ_W'(101));
        run_motion(70);

        // widest threshold, no wrap ever, no idling on either side
        write_threshold(eur_pkg::READ_W'(READ_MAX));
        idle_pct = 0;
        send_reading('0);
        send_reading(eur_pkg::READ_W'(READ_MAX));
        send_reading('0);
        run_motion(70);
        idle_pct = IDLE_PCT;

        write_threshold(eur_pkg::READ_W'($urandom_range(0, READ_MAX)));
        hold_pending = 1'b1;
        run_motion(100);

        write_threshold(eur_pkg::READ_W'(1));
        run_motion(60);

        write_threshold(eur_pkg::READ_W'(eur_pkg::THRESHOLD_RESET));
        run_motion(60);

        write_threshold(eur_pkg::READ_W'(eur_pkg::HALF_TURN));
        run_motion(60);

        wait_for_drain();
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== encoder_unwrap_rate_averager.f =====
hdl/eur_pkg.sv
hdl/eur_avg.sv
hdl/encoder_unwrap_rate_averager.sv
hdl/eur_checker.sv
tb/encoder_unwrap_rate_averager_tb.sv
